### rtl/accumulator_cpu_execute_defines.svh
// Assertion helpers used by accumulator_cpu_execute.sv.
`ifndef ACCUMULATOR_CPU_EXECUTE_DEFINES_SVH
`define ACCUMULATOR_CPU_EXECUTE_DEFINES_SVH

// Same-cycle implication.
`define ACPU_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ACPU_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/acpu_pkg.sv
package acpu_pkg;

  // Memory depth is a power of two so address wrap is a bit select.
  localparam int MEM_ADDR_W = 12;
  localparam int MEM_WORDS  = 1 << MEM_ADDR_W;

  typedef enum logic [4:0] {
    OP_LDC    = 5'd0,
    OP_ADC    = 5'd1,
    OP_LDL    = 5'd2,
    OP_STL    = 5'd3,
    OP_LDNL   = 5'd4,
    OP_STNL   = 5'd5,
    OP_ADD    = 5'd6,
    OP_SUB    = 5'd7,
    OP_SHL    = 5'd8,
    OP_SHR    = 5'd9,
    OP_ADJ    = 5'd10,
    OP_A2SP   = 5'd11,
    OP_SP2A   = 5'd12,
    OP_CALL   = 5'd13,
    OP_RETURN = 5'd14,
    OP_BRZ    = 5'd15,
    OP_BRLZ   = 5'd16,
    OP_BR     = 5'd17,
    OP_HALT   = 5'd18
  } opcode_t;

  typedef struct packed {
    logic               mode;
    logic [4:0]         opcode;
    logic signed [23:0] operand;
    logic [11:0]        load_address;
    logic signed [31:0] load_data;
  } in_item_t;

  // Also used as the architectural state register.
  typedef struct packed {
    logic signed [31:0] reg_a;
    logic signed [31:0] reg_b;
    logic signed [31:0] stack_pointer;
    logic signed [31:0] program_counter;
    logic               halted;
  } out_item_t;

  typedef struct packed {
    logic                  en;
    logic [MEM_ADDR_W-1:0] addr;
    logic [31:0]           data;
  } mem_wr_t;

  function automatic logic [31:0] sext_operand(input logic signed [23:0] ofs);
    return {{8{ofs[23]}}, ofs};
  endfunction

  // base + offset, wrapped to the memory depth
  function automatic logic [MEM_ADDR_W-1:0] mem_index(input logic [31:0] base,
                                                      input logic signed [23:0] ofs);
    logic [31:0] sum;
    sum = base + sext_operand(ofs);
    return sum[MEM_ADDR_W-1:0];
  endfunction

endpackage

### rtl/acpu_ram.sv
module acpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/acpu_alu.sv
module acpu_alu (
  input  acpu_pkg::out_item_t st,
  input  acpu_pkg::in_item_t  item,
  input  logic [31:0]         rd_data,
  output acpu_pkg::out_item_t st_nxt,
  output acpu_pkg::mem_wr_t   mem_wr
);
  import acpu_pkg::*;

  logic [31:0] cur_a, cur_b, cur_sp, cur_pc, v;
  logic [31:0] a_n, b_n, sp_n, pc_n;
  logic        halt_n;
  logic [31:0] load_addr_ext;
  logic [4:0]  shr_amt;

  always_comb begin
    cur_a   = st.reg_a;
    cur_b   = st.reg_b;
    cur_sp  = st.stack_pointer;
    cur_pc  = st.program_counter;
    v       = sext_operand(item.operand);
    a_n     = cur_a;
    b_n     = cur_b;
    sp_n    = cur_sp;
    pc_n    = cur_pc;
    halt_n  = st.halted;
    mem_wr  = '0;
    load_addr_ext = 32'(item.load_address);
    shr_amt = (cur_a > 32'd31) ? 5'd31 : cur_a[4:0];

    if (!st.halted) begin
      if (item.mode) begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = load_addr_ext[MEM_ADDR_W-1:0];
        mem_wr.data = item.load_data;
      end else begin
        pc_n = cur_pc + 32'd1;
        case (opcode_t'(item.opcode))
          OP_LDC: begin
            b_n = cur_a;
            a_n = v;
          end
          OP_ADC: a_n = cur_a + v;
          OP_LDL: begin
            b_n = cur_a;
            a_n = rd_data;
          end
          OP_STL: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = mem_index(cur_sp, item.operand);
            mem_wr.data = cur_a;
            a_n         = cur_b;
          end
          OP_LDNL: a_n = rd_data;
          OP_STNL: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = mem_index(cur_a, item.operand);
            mem_wr.data = cur_b;
          end
          OP_ADD: a_n = cur_b + cur_a;
          OP_SUB: a_n = cur_b - cur_a;
          OP_SHL: a_n = (cur_a > 32'd31) ? 32'd0 : (cur_b << cur_a[4:0]);
          OP_SHR: a_n = 32'($signed(cur_b) >>> shr_amt);
          OP_ADJ: sp_n = cur_sp + v;
          OP_A2SP: begin
            sp_n = cur_a;
            a_n  = cur_b;
          end
          OP_SP2A: begin
            b_n = cur_a;
            a_n = cur_sp;
          end
          OP_CALL: begin
            b_n  = cur_a;
            a_n  = cur_pc;
            pc_n = cur_pc + v;
          end
          OP_RETURN: begin
            pc_n = cur_a + 32'd1;
            a_n  = cur_b;
          end
          OP_BRZ: begin
            if (cur_a == 32'd0) begin
              pc_n = cur_pc + v;
            end
          end
          OP_BRLZ: begin
            if (cur_a[31]) begin
              pc_n = cur_pc + v;
            end
          end
          OP_BR: pc_n = cur_pc + v;
          OP_HALT: begin
            halt_n = 1'b1;
            pc_n   = cur_pc;
          end
          default: ;
        endcase
      end
    end

    st_nxt.reg_a           = a_n;
    st_nxt.reg_b           = b_n;
    st_nxt.stack_pointer   = sp_n;
    st_nxt.program_counter = pc_n;
    st_nxt.halted          = halt_n;
  end

endmodule

### rtl/accumulator_cpu_execute.sv
// Execute unit of a two-register (A, B) accumulator machine with stack
// pointer, program counter and a 4096-word data memory. Each request on the
// in_ channel is either one instruction (mode 0) or a memory preload word
// (mode 1), and produces exactly one result on the out_ channel: the
// register state after that request. The unit sustains one request per
// clock while out_stall does not hold the result register; a result is
// registered first in the read port of the data memory, then by the
// execute step into the result register. Loads read memory at accept
// time with the address formed from the state forwarded out of the
// instruction executing in that cycle, and a store from that instruction to
// the same word is bypassed. After reset the memory is cleared one word per
// cycle, and in_stall stays high until all 4096 words are cleared. Once
// a halt has executed, every further request returns the unchanged state.
`include "accumulator_cpu_execute_defines.svh"

module accumulator_cpu_execute (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  acpu_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output acpu_pkg::out_item_t out_data
);
  import acpu_pkg::*;

  // architectural state
  out_item_t st_r, st_nxt;

  // execute stage: request whose memory read is in flight
  logic     ex_valid_r;
  in_item_t ex_item_r;

  // result register
  logic      out_valid_r;
  out_item_t out_data_r;

  // clear pass after reset
  logic                  clear_busy_r;
  logic [MEM_ADDR_W-1:0] clear_addr_r;

  // store-to-load bypass
  logic        byp_valid_r;
  logic [31:0] byp_data_r;

  logic                  out_ready, ex_fire, in_fire;
  out_item_t             fwd;
  logic [31:0]           rd_base;
  logic [MEM_ADDR_W-1:0] rd_addr;
  logic [31:0]           ram_rdata, rd_data;
  mem_wr_t               mem_wr;
  logic                  ram_we;
  logic [MEM_ADDR_W-1:0] ram_waddr;
  logic [31:0]           ram_wdata;
  logic                  byp_hit;

  // The execute stage moves on whenever the result register is free or
  // being emptied; a new request enters whenever the stage will be free and the clear pass is over.
  assign out_ready = !out_valid_r || !out_stall;
  assign ex_fire   = ex_valid_r && out_ready;
  assign in_stall  = clear_busy_r || (ex_valid_r && !out_ready);
  assign in_fire   = in_valid && !in_stall;

  acpu_alu u_alu (
    .st     (st_r),
    .item   (ex_item_r),
    .rd_data(rd_data),
    .st_nxt (st_nxt),
    .mem_wr (mem_wr)
  );

  // Load address is computed from the state the executing instruction
  // leaves behind, so dependent loads can issue back to back.
  always_comb begin
    fwd     = ex_fire ? st_nxt : st_r;
    rd_base = (opcode_t'(in_data.opcode) == OP_LDNL) ? fwd.reg_a : fwd.stack_pointer;
    rd_addr = mem_index(rd_base, in_data.operand);
  end

  // A store retiring in the same cycle as the read would be missed by the
  // RAM, so capture its data alongside.
  assign byp_hit = ex_fire && mem_wr.en && (mem_wr.addr == rd_addr);
  assign rd_data = byp_valid_r ? byp_data_r : ram_rdata;

  // Single write port: clear pass first, then retiring stores.
  always_comb begin
    if (clear_busy_r) begin
      ram_we    = 1'b1;
      ram_waddr = clear_addr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = ex_fire && mem_wr.en;
      ram_waddr = mem_wr.addr;
      ram_wdata = mem_wr.data;
    end
  end

  acpu_ram #(
    .WIDTH(32),
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (in_fire),
    .raddr(rd_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= '0;
      ex_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      clear_busy_r <= 1'b1;
      clear_addr_r <= '0;
      byp_valid_r  <= 1'b0;
    end else begin
      if (clear_busy_r) begin
        clear_addr_r <= clear_addr_r + 1'b1;
        if (clear_addr_r == {MEM_ADDR_W{1'b1}}) begin
          clear_busy_r <= 1'b0;
        end
      end

      if (in_fire) begin
        ex_valid_r  <= 1'b1;
        byp_valid_r <= byp_hit;
      end else if (ex_fire) begin
        ex_valid_r <= 1'b0;
      end

      if (ex_fire) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      ex_item_r  <= in_data;
      byp_data_r <= mem_wr.data;
    end
    if (ex_fire) begin
      out_data_r <= st_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // nothing executes while memory is still being cleared
  `ACPU_ASSERT_IMP(a_no_exec_in_clear, clk, rst_n, clear_busy_r, !ex_valid_r && !ram_we || !ex_valid_r)
  // halt is sticky
  `ACPU_ASSERT_NXT(a_halt_sticky, clk, rst_n, st_r.halted, st_r.halted)
  // a halted machine reports its state unchanged
  `ACPU_ASSERT_NXT(a_halt_frozen, clk, rst_n, ex_fire && st_r.halted, $stable(st_r))
  // a retiring request publishes exactly the new state
  `ACPU_ASSERT_NXT(a_result_is_state, clk, rst_n, ex_fire, out_valid_r && (out_data_r == st_r))

endmodule
